// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`else

`define ASSERT_IMPLIES(lbl, ante, cons)

`define ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== rtl/r2i_pkg.sv =====
// ----------------------------------------------------------------------------
// r2i_pkg
// Constants and widths for the RGB to I420 converter.
// ----------------------------------------------------------------------------
package r2i_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ADDR_W     = (COL_W > 1) ? COL_W - 1 : 1;
    localparam int HALF_DEPTH = (MAX_WIDTH + 1) / 2;
    localparam int CFG_W      = 12;
    localparam int LIM_W      = (COL_W + 1 > CFG_W) ? COL_W + 1 : CFG_W;

    localparam int COMP_W = 8;
    localparam int PIX_W  = 3 * COMP_W;
    localparam int PROD_W = 24;
    localparam int SUM_W  = 25;

    localparam logic [CFG_W-1:0] IMAGE_WIDTH_RESET = CFG_W'(640);

    // 16-bit fractions of the colour matrix
    localparam logic [15:0] C_YR = 16'd19595;
    localparam logic [15:0] C_YG = 16'd38470;
    localparam logic [15:0] C_YB = 16'd7471;
    localparam logic [15:0] C_UR = 16'd11076;
    localparam logic [15:0] C_UG = 16'd21692;
    localparam logic [15:0] C_VG = 16'd27460;
    localparam logic [15:0] C_VB = 16'd5308;

    // 128.5 in 16.16
    localparam logic [SUM_W-1:0] C_OFFSET = SUM_W'(8421376);

endpackage

// ===== rtl/r2i_pixel_if.sv =====
// ----------------------------------------------------------------------------
// r2i_pixel_if
// Valid/ready channel carrying one RGB pixel with its frame marker.
// ----------------------------------------------------------------------------
interface r2i_pixel_if;

    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       frame_start;

    modport source (output valid, output red, output green, output blue,
                    output frame_start, input ready);
    modport sink (input valid, input red, input green, input blue,
                  input frame_start, output ready);

endinterface

// ===== rtl/r2i_result_if.sv =====
// ----------------------------------------------------------------------------
// r2i_result_if
// Valid/ready channel carrying luma and, on block closure, chroma.
// ----------------------------------------------------------------------------
interface r2i_result_if;

    logic       valid;
    logic       ready;
    logic [7:0] luma;
    logic       chroma_valid;
    logic [7:0] chroma_u;
    logic [7:0] chroma_v;

    modport source (output valid, output luma, output chroma_valid,
                    output chroma_u, output chroma_v, input ready);
    modport sink (input valid, input luma, input chroma_valid,
                  input chroma_u, input chroma_v, output ready);

endinterface

// ===== rtl/rgb_to_i420_converter.sv =====
// ----------------------------------------------------------------------------
// rgb_to_i420_converter
// Raster RGB pixel stream to per-pixel luma plus 2x2-averaged U/V.
// ----------------------------------------------------------------------------
// Takes one pixel per clock unless stalled from the output, and returns one
// result per pixel through line store read, average and luma products, chroma
// products, and final sums and saturation. The previous even row is held in two
// single-port-write RAMs of MAX_WIDTH/2 x 24 bits, one for even and one for
// odd columns, so both upper pixels of a block are read out together.
// Each stage moves on when the stage after it is empty or moving, so the
// input keeps flowing into bubbles while a finished result waits at the
// output. The line store has no reset; rows are always written before read.
// image_width is clamped to 2..MAX_WIDTH and should change only when idle.
module rgb_to_i420_converter
    import r2i_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_wdata,
    r2i_pixel_if.sink        pixel,
    r2i_result_if.source     result
);

`include "assert_macros.svh"

    // configuration
    logic [CFG_W-1:0] image_width_reg;
    logic [LIM_W-1:0] width_lim;

    // position state
    logic [COL_W-1:0] col_reg, col_next;
    logic             row_odd_reg, row_odd_next;
    logic [PIX_W-1:0] left_reg;

    logic             accept;
    logic [COL_W-1:0] cur_col;
    logic             cur_row_odd;
    logic [LIM_W-1:0] col_inc;
    logic [PIX_W-1:0] cur_pix;
    logic [ADDR_W-1:0] mem_addr;

    // line store
    logic [PIX_W-1:0] even_mem [HALF_DEPTH];
    logic [PIX_W-1:0] odd_mem  [HALF_DEPTH];

    // stage enables
    logic en1, en2, en3, en_out;

    // stage 1
    logic              s1_v_reg;
    logic [PIX_W-1:0]  s1_pix_reg;
    logic [PIX_W-1:0]  s1_left_reg;
    logic              s1_chroma_reg;
    logic [PIX_W-1:0]  s1_up_reg;
    logic [PIX_W-1:0]  s1_ul_reg;

    // stage 2
    logic              s2_v_reg;
    logic [PROD_W-1:0] s2_yr_reg, s2_yg_reg, s2_yb_reg;
    logic [COMP_W-1:0] s2_ra_reg, s2_ga_reg, s2_ba_reg;
    logic              s2_chroma_reg;
    logic [COMP_W+1:0] sum_r, sum_g, sum_b;

    // stage 3
    logic              s3_v_reg;
    logic [COMP_W-1:0] s3_luma_reg;
    logic              s3_chroma_reg;
    logic [PROD_W-1:0] s3_ur_reg, s3_ug_reg, s3_vg_reg, s3_vb_reg;
    logic [COMP_W-1:0] s3_ra_reg, s3_ba_reg;
    logic [PROD_W-1:0] luma_sum;

    // output
    logic              out_v_reg;
    logic [COMP_W-1:0] out_luma_reg;
    logic              out_chroma_reg;
    logic [COMP_W-1:0] out_u_reg, out_v_val_reg;
    logic [SUM_W-1:0]  u_sum, v_sum;
    logic [COMP_W-1:0] u_sat, v_sat;

    // ------------------------------------------------------------------
    // handshake
    // ------------------------------------------------------------------
    assign en_out      = !out_v_reg || result.ready;
    assign en3         = !s3_v_reg || en_out;
    assign en2         = !s2_v_reg || en3;
    assign en1         = !s1_v_reg || en2;
    assign pixel.ready = en1;
    assign accept      = pixel.valid && en1;

    // ------------------------------------------------------------------
    // position tracking
    // ------------------------------------------------------------------
    always_comb
    begin
        if (LIM_W'(image_width_reg) < LIM_W'(2))
        begin
            width_lim = LIM_W'(2);
        end
        else if (LIM_W'(image_width_reg) > LIM_W'(MAX_WIDTH))
        begin
            width_lim = LIM_W'(MAX_WIDTH);
        end
        else
        begin
            width_lim = LIM_W'(image_width_reg);
        end
    end

    assign cur_col     = pixel.frame_start ? '0 : col_reg;
    assign cur_row_odd = pixel.frame_start ? 1'b0 : row_odd_reg;
    assign col_inc     = LIM_W'(cur_col) + LIM_W'(1);
    assign cur_pix     = {pixel.red, pixel.green, pixel.blue};
    assign mem_addr    = ADDR_W'(cur_col >> 1);

    always_comb
    begin
        if (col_inc >= width_lim)
        begin
            col_next     = '0;
            row_odd_next = !cur_row_odd;
        end
        else
        begin
            col_next     = COL_W'(col_inc);
            row_odd_next = cur_row_odd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg <= IMAGE_WIDTH_RESET;
            col_reg         <= '0;
            row_odd_reg     <= 1'b0;
            left_reg        <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                image_width_reg <= cfg_wdata;
            end
            if (accept)
            begin
                col_reg     <= col_next;
                row_odd_reg <= row_odd_next;
                left_reg    <= cur_pix;
            end
        end
    end

    // ------------------------------------------------------------------
    // line store: written on even rows, read on odd rows
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (accept && !cur_row_odd && !cur_col[0])
        begin
            even_mem[mem_addr] <= cur_pix;
        end
        if (en1)
        begin
            s1_ul_reg <= even_mem[mem_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && !cur_row_odd && cur_col[0])
        begin
            odd_mem[mem_addr] <= cur_pix;
        end
        if (en1)
        begin
            s1_up_reg <= odd_mem[mem_addr];
        end
    end

    // ------------------------------------------------------------------
    // pipeline valids
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg  <= 1'b0;
            s2_v_reg  <= 1'b0;
            s3_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                s1_v_reg <= pixel.valid;
            end
            if (en2)
            begin
                s2_v_reg <= s1_v_reg;
            end
            if (en3)
            begin
                s3_v_reg <= s2_v_reg;
            end
            if (en_out)
            begin
                out_v_reg <= s3_v_reg;
            end
        end
    end

    // ------------------------------------------------------------------
    // datapath
    // ------------------------------------------------------------------
    assign sum_r = (COMP_W+2)'(s1_pix_reg[23:16]) + (COMP_W+2)'(s1_left_reg[23:16])
                 + (COMP_W+2)'(s1_up_reg[23:16]) + (COMP_W+2)'(s1_ul_reg[23:16]);
    assign sum_g = (COMP_W+2)'(s1_pix_reg[15:8]) + (COMP_W+2)'(s1_left_reg[15:8])
                 + (COMP_W+2)'(s1_up_reg[15:8]) + (COMP_W+2)'(s1_ul_reg[15:8]);
    assign sum_b = (COMP_W+2)'(s1_pix_reg[7:0]) + (COMP_W+2)'(s1_left_reg[7:0])
                 + (COMP_W+2)'(s1_up_reg[7:0]) + (COMP_W+2)'(s1_ul_reg[7:0]);

    assign luma_sum = s2_yr_reg + s2_yg_reg + s2_yb_reg;

    // U and V stay in 1..256
    assign u_sum = C_OFFSET + (SUM_W'(s3_ba_reg) << 15)
                 - SUM_W'(s3_ur_reg) - SUM_W'(s3_ug_reg);
    assign v_sum = C_OFFSET + (SUM_W'(s3_ra_reg) << 15)
                 - SUM_W'(s3_vg_reg) - SUM_W'(s3_vb_reg);
    assign u_sat = u_sum[24] ? '1 : u_sum[23:16];
    assign v_sat = v_sum[24] ? '1 : v_sum[23:16];

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_pix_reg    <= cur_pix;
            s1_left_reg   <= left_reg;
            s1_chroma_reg <= cur_row_odd && cur_col[0];
        end
        if (en2)
        begin
            s2_yr_reg     <= PROD_W'(C_YR) * PROD_W'(s1_pix_reg[23:16]);
            s2_yg_reg     <= PROD_W'(C_YG) * PROD_W'(s1_pix_reg[15:8]);
            s2_yb_reg     <= PROD_W'(C_YB) * PROD_W'(s1_pix_reg[7:0]);
            s2_ra_reg     <= sum_r[COMP_W+1:2];
            s2_ga_reg     <= sum_g[COMP_W+1:2];
            s2_ba_reg     <= sum_b[COMP_W+1:2];
            s2_chroma_reg <= s1_chroma_reg;
        end
        if (en3)
        begin
            s3_luma_reg   <= luma_sum[23:16];
            s3_chroma_reg <= s2_chroma_reg;
            s3_ur_reg     <= PROD_W'(C_UR) * PROD_W'(s2_ra_reg);
            s3_ug_reg     <= PROD_W'(C_UG) * PROD_W'(s2_ga_reg);
            s3_vg_reg     <= PROD_W'(C_VG) * PROD_W'(s2_ga_reg);
            s3_vb_reg     <= PROD_W'(C_VB) * PROD_W'(s2_ba_reg);
            s3_ra_reg     <= s2_ra_reg;
            s3_ba_reg     <= s2_ba_reg;
        end
        if (en_out)
        begin
            out_luma_reg   <= s3_luma_reg;
            out_chroma_reg <= s3_chroma_reg;
            out_u_reg      <= s3_chroma_reg ? u_sat : '0;
            out_v_val_reg  <= s3_chroma_reg ? v_sat : '0;
        end
    end

    assign result.valid        = out_v_reg;
    assign result.luma         = out_luma_reg;
    assign result.chroma_valid = out_chroma_reg;
    assign result.chroma_u     = out_u_reg;
    assign result.chroma_v     = out_v_val_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `ASSERT_IMPLIES(a_no_chroma_zero,
        result.valid && !result.chroma_valid,
        result.chroma_u == 8'd0 && result.chroma_v == 8'd0)
    `ASSERT_IMPLIES(a_chroma_nonzero,
        result.valid && result.chroma_valid,
        result.chroma_u != 8'd0 && result.chroma_v != 8'd0)
    `ASSERT_NEXT(a_frame_restart, accept && pixel.frame_start,
        col_reg == COL_W'(1) && !row_odd_reg)
    `ASSERT_IMPLIES(a_ready_when_drained, !out_v_reg, pixel.ready)

endmodule

// ===== dv/tb_rgb_to_i420_converter.sv =====
// ----------------------------------------------------------------------------
// tb_rgb_to_i420_converter
// Self-checking bench: raster pixel frames at several row widths, each
// converted result compared against an in-bench luma/chroma predictor.
// ----------------------------------------------------------------------------
module tb_rgb_to_i420_converter;
    timeunit 1ns;
    timeprecision 1ps;

    import r2i_pkg::*;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       frame_start;
    } pixel_t;

    typedef struct packed {
        logic [7:0] luma;
        logic       chroma_valid;
        logic [7:0] chroma_u;
        logic [7:0] chroma_v;
    } yuv_t;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_AT     = 150;
    localparam int HOLD_CYCLES = 80;
    localparam int NUM_PHASES  = 9;

    localparam int unsigned K_YR   = 19595;
    localparam int unsigned K_YG   = 38470;
    localparam int unsigned K_YB   = 7471;
    localparam int unsigned K_UR   = 11076;
    localparam int unsigned K_UG   = 21692;
    localparam int unsigned K_HALF = 32768;
    localparam int unsigned K_VG   = 27460;
    localparam int unsigned K_VB   = 5308;
    localparam int unsigned K_OFS  = 8421376;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [CFG_W-1:0] cfg_wdata;

    r2i_pixel_if  pix_bus ();
    r2i_result_if res_bus ();

    rgb_to_i420_converter u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .pixel     (pix_bus),
        .result    (res_bus)
    );

    pixel_t pending_px[$];
    yuv_t   expected_yuv[$];

    // predictor state
    logic [23:0] line_buf [MAX_WIDTH];
    logic [23:0] prev_px = '0;
    int unsigned col_pos = 0;
    logic        odd_row = 1'b0;
    int unsigned row_len = 640;

    // stimulus position tracking, keeps odd rows off unwritten line entries
    bit          gen_written [MAX_WIDTH];
    int unsigned gen_col;
    bit          gen_odd;
    int unsigned gen_len;

    int pix_sent   = 0;
    int mismatches = 0;
    int cycles     = 0;
    int hold_left  = 0;
    bit hold_done  = 1'b0;
    bit pix_took;

    int phase_cfg [NUM_PHASES] = '{7, 6, 3, 12, 1, 33, 9, 2, 4095};
    int phase_len [NUM_PHASES] = '{120, 53, 41, 97, 60, 200, 67, 80, 30};
    bit phase_cont [NUM_PHASES] = '{0, 0, 1, 1, 0, 0, 0, 1, 0};

    function automatic int unsigned clamp_width(int unsigned v);
        if (v < 2)
            return 2;
        if (v > MAX_WIDTH)
            return MAX_WIDTH;
        return v;
    endfunction

    function automatic logic [7:0] sat_byte(int unsigned v);
        return (v > 255) ? 8'd255 : v[7:0];
    endfunction

    function automatic yuv_t convert_pixel(pixel_t p);
        yuv_t        res;
        int unsigned x, r, g, b, ra, ga, ba;
        logic [23:0] up, ul, px;
        r  = p.red;
        g  = p.green;
        b  = p.blue;
        px = {p.red, p.green, p.blue};
        if (p.frame_start)
        begin
            col_pos = 0;
            odd_row = 1'b0;
        end
        if (col_pos >= MAX_WIDTH)
            col_pos = 0;
        x = col_pos;
        res.luma         = 8'((K_YR * r + K_YG * g + K_YB * b) >> 16);
        res.chroma_valid = 1'b0;
        res.chroma_u     = 8'd0;
        res.chroma_v     = 8'd0;
        if (odd_row && (x % 2 == 1))
        begin
            up = line_buf[x];
            ul = line_buf[x - 1];
            ra = (r + prev_px[23:16] + up[23:16] + ul[23:16]) >> 2;
            ga = (g + prev_px[15:8] + up[15:8] + ul[15:8]) >> 2;
            ba = (b + prev_px[7:0] + up[7:0] + ul[7:0]) >> 2;
            res.chroma_valid = 1'b1;
            res.chroma_u = sat_byte((K_OFS + K_HALF * ba - K_UR * ra - K_UG * ga) >> 16);
            res.chroma_v = sat_byte((K_OFS + K_HALF * ra - K_VG * ga - K_VB * ba) >> 16);
        end
        if (!odd_row)
            line_buf[x] = px;
        prev_px = px;
        col_pos = x + 1;
        if (col_pos >= row_len)
        begin
            col_pos = 0;
            odd_row = !odd_row;
        end
        return res;
    endfunction

    function automatic void queue_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, bit fs);
        pixel_t      p;
        int unsigned x;
        bit          odd;
        p.frame_start = fs;
        x   = fs ? 0 : gen_col;
        odd = fs ? 1'b0 : gen_odd;
        if (odd && (x % 2 == 1) && !(gen_written[x] && gen_written[x - 1]))
        begin
            p.frame_start = 1'b1;
            x   = 0;
            odd = 1'b0;
        end
        if (!odd)
            gen_written[x] = 1'b1;
        gen_col = x + 1;
        gen_odd = odd;
        if (gen_col >= gen_len)
        begin
            gen_col = 0;
            gen_odd = !odd;
        end
        p.red   = r;
        p.green = g;
        p.blue  = b;
        pending_px.insert(pending_px.size(), p);
    endfunction

    function automatic logic [7:0] rand_comp();
        case ($urandom_range(0, 9))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic int tx_idle_pct();
        return (pix_sent < 250) ? 9 : (pix_sent < 500) ? 58 : 0;
    endfunction

    function automatic int rx_idle_pct();
        return (pix_sent < 250) ? 58 : (pix_sent < 500) ? 9 : 0;
    endfunction

    task automatic wait_drained();
        @(posedge clk);
        while (pending_px.size() != 0 || pix_bus.valid || expected_yuv.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_width(int val);
        wait_drained();
        @(negedge clk);
        cfg_wdata <= CFG_W'(val);
        cfg_we    <= 1'b1;
        @(negedge clk);
        cfg_we  <= 1'b0;
        gen_len = clamp_width(CFG_W'(val));
    endtask

    task automatic queue_block(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        for (int k = 0; k < 4; k++)
            queue_pixel(r, g, b, k == 0);
    endtask

    task automatic run_phase(int cfg_val, int n, bit cont);
        int  frame_left;
        bit  fs;
        write_width(cfg_val);
        frame_left = cont ? gen_len * $urandom_range(1, 3) : 0;
        for (int i = 0; i < n; i++)
        begin
            fs = 1'b0;
            if (frame_left == 0 || (gen_len <= 64 && $urandom_range(0, 99) < 2))
            begin
                fs = 1'b1;
                frame_left = gen_len * $urandom_range(1, 5);
            end
            frame_left--;
            queue_pixel(rand_comp(), rand_comp(), rand_comp(), fs);
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // sender
    always @(negedge clk)
    begin
        pixel_t p;
        if (!rst_n)
        begin
            pix_bus.valid       <= 1'b0;
            pix_bus.red         <= '0;
            pix_bus.green       <= '0;
            pix_bus.blue        <= '0;
            pix_bus.frame_start <= 1'b0;
        end
        else if (!pix_bus.valid || pix_took)
        begin
            if (pending_px.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct())
            begin
                p = pending_px.pop_front();
                pix_bus.valid       <= 1'b1;
                pix_bus.red         <= p.red;
                pix_bus.green       <= p.green;
                pix_bus.blue        <= p.blue;
                pix_bus.frame_start <= p.frame_start;
            end
            else
            begin
                pix_bus.valid <= 1'b0;
            end
        end
    end

    // receiver, with one long hold-off to back the pipeline up
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            res_bus.ready <= 1'b0;
            hold_left     <= hold_left - 1;
        end
        else if (!hold_done && pix_sent >= HOLD_AT)
        begin
            res_bus.ready <= 1'b0;
            hold_left     <= HOLD_CYCLES;
            hold_done     <= 1'b1;
        end
        else
        begin
            res_bus.ready <= ($urandom_range(0, 99) >= rx_idle_pct());
        end
    end

    // monitor: check results, then predict from this edge's input transfer
    always @(posedge clk)
    begin
        yuv_t got, want;
        if (!rst_n)
        begin
            pix_took <= 1'b0;
        end
        else
        begin
            pix_took <= pix_bus.valid && pix_bus.ready;
            if (cfg_we)
                row_len = clamp_width(cfg_wdata);
            if (res_bus.valid && res_bus.ready)
            begin
                got = '{res_bus.luma, res_bus.chroma_valid,
                        res_bus.chroma_u, res_bus.chroma_v};
                if (expected_yuv.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected transfer: luma=%0d cv=%0d u=%0d v=%0d",
                                 got.luma, got.chroma_valid, got.chroma_u, got.chroma_v);
                end
                else
                begin
                    want = expected_yuv.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: exp luma=%0d cv=%0d u=%0d v=%0d,",
                                      " got luma=%0d cv=%0d u=%0d v=%0d"},
                                     want.luma, want.chroma_valid, want.chroma_u,
                                     want.chroma_v, got.luma, got.chroma_valid,
                                     got.chroma_u, got.chroma_v);
                    end
                end
            end
            if (pix_bus.valid && pix_bus.ready)
            begin
                want = convert_pixel('{pix_bus.red, pix_bus.green,
                                       pix_bus.blue, pix_bus.frame_start});
                expected_yuv.insert(expected_yuv.size(), want);
                pix_sent++;
            end
        end
    end

    initial
    begin
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        gen_col   = 0;
        gen_odd   = 1'b0;
        gen_len   = 640;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // luma extremes at the reset width
        queue_pixel(8'd0, 8'd0, 8'd0, 1'b1);
        queue_pixel(8'd255, 8'd255, 8'd255, 1'b0);
        queue_pixel(8'd255, 8'd0, 8'd0, 1'b0);
        queue_pixel(8'd0, 8'd255, 8'd0, 1'b0);
        queue_pixel(8'd0, 8'd0, 8'd255, 1'b0);

        // width below range, clamps to 2: chroma saturation and minima
        write_width(0);
        queue_block(8'd0, 8'd0, 8'd255);
        queue_block(8'd255, 8'd0, 8'd0);
        queue_block(8'd255, 8'd255, 8'd0);
        queue_block(8'd0, 8'd255, 8'd255);
        queue_pixel(8'd1, 8'd2, 8'd3, 1'b0);
        queue_pixel(8'd200, 8'd100, 8'd50, 1'b1);

        for (int ph = 0; ph < NUM_PHASES; ph++)
            run_phase(phase_cfg[ph], phase_len[ph], phase_cont[ph]);

        wait_drained();
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
